// ----- design/ccsc_pkg.sv -----
// Package for the CRC codeword stream checker: transaction types, register codes, constants.
package ccsc_pkg;

  localparam int GEN_W      = 17;
  localparam int GEN_LEN_W  = 5;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int BYTE_BITS  = 8;
  localparam int DATA_W     = 8;
  localparam int CNT_OUT_W  = 32;
  localparam int LEN_W      = 6;

  localparam logic [GEN_W-1:0]     GEN_BITS_RST = 17'd7;
  localparam logic [GEN_LEN_W-1:0] GEN_LEN_RST  = 5'd3;
  localparam logic                 DW_EIGHT_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEN_BITS = 2'd0,
    CFG_GEN_LEN  = 2'd1,
    CFG_DW_EIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 has_codeword;
    logic [DATA_W-1:0]    dataword;
    logic                 codeword_error;
    logic [CNT_OUT_W-1:0] codewords_seen;
    logic [CNT_OUT_W-1:0] errors_seen;
    logic                 final_result;
  } out_item_t;

  // Decoded configuration shared by the front and back ends.
  typedef struct packed {
    logic [GEN_W-1:0] gen_bits;
    logic [LEN_W-1:0] glen;
    logic [LEN_W-1:0] deg;
    logic [LEN_W-1:0] size;
    logic             dw8;
  } cfg_t;

endpackage

// ----- design/ccsc_fifo.sv -----
// Small register-based FIFO used between the front end, back end and output port.
module ccsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_en) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/ccsc_front.sv -----
// Front end: header and padding skip, bit collection and codeword framing per byte.
module ccsc_front import ccsc_pkg::*; #(
  parameter int MAX_DEGREE = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  in_item_t                in_data_i,
  input  logic                    mid_full_i,
  input  cfg_t                    cfg_i,
  output logic                    wr_o,
  output logic [1:0]              ncw_o,
  output logic [MAX_DEGREE+7:0]   cw0_o,
  output logic [MAX_DEGREE+7:0]   cw1_o,
  output logic                    last_o
);

  localparam int W     = MAX_DEGREE + 8;
  localparam int CNT_W = $clog2(W + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic                 hdr_q, hdr_d;
  logic [BYTE_BITS-1:0] skip_q, skip_d;
  logic [W-1:0]         sh_q, sh_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic [BYTE_BITS-1:0] skip_w;
  logic [W-1:0]         sh_w, cw_mask, cw0_w, cw1_w;
  logic [CNT_W-1:0]     cnt_w;
  logic [1:0]           ncw_w;
  logic                 accept;

  assign accept  = push_i && !mid_full_i;
  assign cw_mask = ~({W{1'b1}} << cfg_i.size);

  // Eight bit steps per byte.
  always_comb begin
    skip_w = skip_q;
    sh_w   = sh_q;
    cnt_w  = cnt_q;
    ncw_w  = '0;
    cw0_w  = '0;
    cw1_w  = '0;
    for (int b = BYTE_BITS - 1; b >= 0; b--) begin
      if (skip_w != '0) begin
        skip_w = skip_w - 1'b1;
      end else begin
        sh_w  = {sh_w[W-2:0], in_data_i.data_byte[b]};
        cnt_w = cnt_w + 1'b1;
        if (CMP_W'(cnt_w) >= CMP_W'(cfg_i.size)) begin
          if (ncw_w == 2'd0) begin
            cw0_w = sh_w & cw_mask;
          end else begin
            cw1_w = sh_w & cw_mask;
          end
          ncw_w = ncw_w + 1'b1;
          sh_w  = '0;
          cnt_w = '0;
        end
      end
    end
  end

  always_comb begin
    hdr_d  = hdr_q;
    skip_d = skip_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (!hdr_q) begin
        hdr_d  = 1'b1;
        skip_d = in_data_i.data_byte;
      end else begin
        skip_d = skip_w;
        sh_d   = sh_w;
        cnt_d  = cnt_w;
      end
      if (in_data_i.last_byte) begin
        hdr_d  = 1'b0;
        skip_d = '0;
        sh_d   = '0;
        cnt_d  = '0;
      end
    end
  end

  assign wr_o   = accept;
  assign ncw_o  = hdr_q ? ncw_w : 2'd0;
  assign cw0_o  = cw0_w;
  assign cw1_o  = cw1_w;
  assign last_o = in_data_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= 1'b0;
      skip_q <= '0;
      sh_q   <= '0;
      cnt_q  <= '0;
    end else begin
      hdr_q  <= hdr_d;
      skip_q <= skip_d;
      sh_q   <= sh_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- design/ccsc_back.sv -----
// Back end: polynomial division, running counts, one result/cycle unless output full.
module ccsc_back import ccsc_pkg::*; #(
  parameter int MAX_DEGREE  = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mid_empty_i,
  input  logic [1:0]            ncw_i,
  input  logic [MAX_DEGREE+7:0] cw0_i,
  input  logic [MAX_DEGREE+7:0] cw1_i,
  input  logic                  last_i,
  input  cfg_t                  cfg_i,
  input  logic                  out_full_i,
  output logic                  mid_pop_o,
  output logic                  out_wr_o,
  output out_item_t             out_item_o
);

  localparam int W    = MAX_DEGREE + 8;
  localparam int GW   = MAX_DEGREE + 1;
  localparam int SH_W = $clog2(W + 1);

  logic [1:0]             step_q, step_d;
  logic [COUNT_WIDTH-1:0] tot_q, tot_d, err_q, err_d, tot_inc, err_inc;

  logic [GW+GEN_W-1:0] gen_ext;
  logic [GW-1:0]       gen, gen_mask;
  logic [W-1:0]        gen_al, cw, cw_al, rem_al, r;
  logic [SH_W-1:0]     gen_sh, cw_sh;
  logic                cw_err, has_cw, more;
  logic [DATA_W-1:0]   dword;

  assign gen_ext  = (GW + GEN_W)'(cfg_i.gen_bits);
  assign gen_mask = ~({GW{1'b1}} << cfg_i.glen);
  assign gen      = gen_ext[GW-1:0] & gen_mask;
  assign gen_sh   = SH_W'(W) - SH_W'(cfg_i.glen);
  assign cw_sh    = SH_W'(W) - SH_W'(cfg_i.size);
  assign gen_al   = W'(gen) << gen_sh;
  assign rem_al   = (~({W{1'b1}} << cfg_i.deg)) << cw_sh;

  assign has_cw = (step_q < ncw_i);
  assign more   = ((step_q + 2'd1) < ncw_i) || last_i;
  assign cw     = step_q[0] ? cw1_i : cw0_i;
  assign cw_al  = cw << cw_sh;
  assign dword  = DATA_W'(cw >> cfg_i.deg);

  // Long division, codeword left aligned, one data bit per step.
  always_comb begin
    r = cw_al;
    for (int x = 0; x < DATA_W; x++) begin
      if ((x < 4 || cfg_i.dw8) && r[W-1-x]) begin
        r = r ^ (gen_al >> x);
      end
    end
  end

  assign cw_err  = |(r & rem_al);
  assign tot_inc = (tot_q == '1) ? tot_q : tot_q + 1'b1;
  assign err_inc = (!cw_err || err_q == '1) ? err_q : err_q + 1'b1;

  always_comb begin
    step_d    = step_q;
    tot_d     = tot_q;
    err_d     = err_q;
    mid_pop_o = 1'b0;
    out_wr_o  = 1'b0;
    if (!mid_empty_i) begin
      if (has_cw) begin
        if (!out_full_i) begin
          out_wr_o = 1'b1;
          tot_d    = tot_inc;
          err_d    = err_inc;
          if (more) begin
            step_d = step_q + 2'd1;
          end else begin
            step_d    = '0;
            mid_pop_o = 1'b1;
          end
        end
      end else if (last_i) begin
        if (!out_full_i) begin
          out_wr_o  = 1'b1;
          tot_d     = '0;
          err_d     = '0;
          step_d    = '0;
          mid_pop_o = 1'b1;
        end
      end else begin
        step_d    = '0;
        mid_pop_o = 1'b1;
      end
    end
  end

  always_comb begin
    out_item_o.has_codeword   = has_cw;
    out_item_o.dataword       = has_cw ? dword : '0;
    out_item_o.codeword_error = has_cw && cw_err;
    out_item_o.codewords_seen = has_cw ? CNT_OUT_W'(tot_inc) : CNT_OUT_W'(tot_q);
    out_item_o.errors_seen    = has_cw ? CNT_OUT_W'(err_inc) : CNT_OUT_W'(err_q);
    out_item_o.final_result   = !has_cw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      tot_q  <= '0;
      err_q  <= '0;
    end else begin
      step_q <= step_d;
      tot_q  <= tot_d;
      err_q  <= err_d;
    end
  end

endmodule

// ----- design/crc_codeword_stream_checker.sv -----
// Top level of the CRC codeword stream checker: configuration, front end, queues, back end.
//
// One byte is taken per cycle while the queue after the front end has room. The front end
// frames codewords from the byte in the cycle it is accepted and hands them to a two-entry
// queue; the back end divides one codeword per cycle and writes one result transaction per
// cycle into a two-entry output queue, both while that output queue has room. A byte causes
// 0 to 3 results, so the sustained byte rate is one per cycle while bytes cause at most one
// result each, and the result port sets the pace otherwise. A result passes through the
// two-entry queue and the output queue before it appears on the result port. No clearing pass follows reset.
module crc_codeword_stream_checker import ccsc_pkg::*; #(
  parameter int MAX_DEGREE  = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int W     = MAX_DEGREE + 8;
  localparam int MID_W = 1 + 2 + 2 * W;
  localparam int OUT_W = $bits(out_item_t);

  logic [GEN_W-1:0]     gen_bits_q;
  logic [GEN_LEN_W-1:0] gen_len_q;
  logic                 dw8_q;
  logic [LEN_W-1:0]     glen, len_in;
  cfg_t                 cfg;

  logic             f_wr, mid_full, mid_empty, mid_pop, f_last;
  logic [1:0]       f_ncw;
  logic [W-1:0]     f_cw0, f_cw1;
  logic [MID_W-1:0] mid_wdata, mid_rdata;

  logic             out_wr, out_full;
  out_item_t        out_item;
  logic [OUT_W-1:0] out_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_bits_q <= GEN_BITS_RST;
      gen_len_q  <= GEN_LEN_RST;
      dw8_q      <= DW_EIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GEN_BITS: gen_bits_q <= cfg_data_i[GEN_W-1:0];
        CFG_GEN_LEN:  gen_len_q  <= cfg_data_i[GEN_LEN_W-1:0];
        CFG_DW_EIGHT: dw8_q      <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  assign len_in = LEN_W'(gen_len_q);

  always_comb begin
    if (len_in < LEN_W'(2)) begin
      glen = LEN_W'(2);
    end else if (len_in > LEN_W'(MAX_DEGREE + 1)) begin
      glen = LEN_W'(MAX_DEGREE + 1);
    end else begin
      glen = len_in;
    end
  end

  always_comb begin
    cfg.gen_bits = gen_bits_q;
    cfg.glen     = glen;
    cfg.deg      = glen - LEN_W'(1);
    cfg.size     = glen - LEN_W'(1) + (dw8_q ? LEN_W'(8) : LEN_W'(4));
    cfg.dw8      = dw8_q;
  end

  ccsc_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .mid_full_i (mid_full),
    .cfg_i      (cfg),
    .wr_o       (f_wr),
    .ncw_o      (f_ncw),
    .cw0_o      (f_cw0),
    .cw1_o      (f_cw1),
    .last_o     (f_last)
  );

  assign full      = mid_full;
  assign mid_wdata = {f_last, f_ncw, f_cw1, f_cw0};

  ccsc_fifo #(
    .WIDTH (MID_W),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_wr),
    .wdata_i (mid_wdata),
    .rd_i    (mid_pop),
    .rdata_o (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  ccsc_back #(
    .MAX_DEGREE  (MAX_DEGREE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .ncw_i       (mid_rdata[2*W+1:2*W]),
    .cw0_i       (mid_rdata[W-1:0]),
    .cw1_i       (mid_rdata[2*W-1:W]),
    .last_i      (mid_rdata[MID_W-1]),
    .cfg_i       (cfg),
    .out_full_i  (out_full),
    .mid_pop_o   (mid_pop),
    .out_wr_o    (out_wr),
    .out_item_o  (out_item)
  );

  ccsc_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (out_wr),
    .wdata_i (out_item),
    .rd_i    (pop),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign out_data_o = out_rdata;

endmodule

// ----- design/ccsc_checker.sv -----
// Port-level checker for the CRC codeword stream checker, bound to the top level.
module ccsc_checker import ccsc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_data_o))
    else $error("result changed while not taken");

  a_final_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.final_result |->
      !out_data_o.has_codeword && out_data_o.dataword == '0 && !out_data_o.codeword_error)
    else $error("final result carries codeword fields");

  a_err_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_data_o.errors_seen <= out_data_o.codewords_seen)
    else $error("error count above codeword count");

  a_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.has_codeword |->
      out_data_o.codewords_seen != '0 &&
      (!out_data_o.codeword_error || out_data_o.errors_seen != '0))
    else $error("codeword result not reflected in counts");

endmodule

bind crc_codeword_stream_checker ccsc_checker u_checker (.*);

// ----- dv/ccsc_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the CRC codeword stream checker: mirrors framing and division, compares.
module ccsc_result_checker import ccsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  in_item_t             in_data_i,
  input  logic                 empty,
  input  logic                 pop,
  input  out_item_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   mismatch_count_o,
  output int                   results_due_o
);

  localparam int MAX_DEG = 16;
  localparam logic [CNT_OUT_W-1:0] CNT_MAX = '1;

  logic [GEN_W-1:0]     poly_q;
  logic [GEN_LEN_W-1:0] poly_len_q;
  logic                 wide_data_q;

  logic                 header_seen;
  logic [7:0]           pad_left;
  logic [23:0]          frame_bits;
  logic [4:0]           frame_count;
  logic [31:0]          cw_total;
  logic [31:0]          bad_total;

  out_item_t            results_due[$];
  int                   mismatches = 0;

  task automatic clear_frame();
    header_seen = 1'b0;
    pad_left    = '0;
    frame_bits  = '0;
    frame_count = '0;
    cw_total    = '0;
    bad_total   = '0;
  endtask

  task automatic add_result(logic has, logic [DATA_W-1:0] dw, logic err, logic fin);
    out_item_t r;
    r.has_codeword   = has;
    r.dataword       = dw;
    r.codeword_error = err;
    r.codewords_seen = cw_total;
    r.errors_seen    = bad_total;
    r.final_result   = fin;
    results_due.push_back(r);
  endtask

  // Frames one byte into codewords and queues the results it causes.
  task automatic frame_byte(in_item_t it);
    int          glen, deg, dw, size, n, b, x;
    logic [31:0] gen, cw, rem, rem_mask;
    logic        err;
    n = 0;
    if (!header_seen) begin
      header_seen = 1'b1;
      pad_left    = it.data_byte;
    end else begin
      glen = poly_len_q;
      if (glen < 2) glen = 2;
      if (glen > MAX_DEG + 1) glen = MAX_DEG + 1;
      deg      = glen - 1;
      dw       = wide_data_q ? 8 : 4;
      size     = dw + deg;
      gen      = 32'(poly_q) & ((32'd1 << glen) - 1);
      rem_mask = (32'd1 << deg) - 1;
      for (b = BYTE_BITS - 1; b >= 0; b--) begin
        if (pad_left != 0) begin
          pad_left--;
        end else begin
          frame_bits = {frame_bits[22:0], it.data_byte[b]};
          frame_count++;
          if (frame_count >= size) begin
            cw  = 32'(frame_bits) & ((32'd1 << size) - 1);
            rem = cw;
            for (x = 0; x < dw; x++) begin
              if (rem[size-1-x]) rem ^= gen << (dw - 1 - x);
            end
            err = (rem & rem_mask) != 0;
            if (cw_total != CNT_MAX) cw_total++;
            if (err && bad_total != CNT_MAX) bad_total++;
            if (n < 3) begin
              add_result(1'b1, DATA_W'(cw >> deg), err, 1'b0);
              n++;
            end
            frame_bits  = '0;
            frame_count = '0;
          end
        end
      end
    end
    if (it.last_byte) begin
      if (n < 3) add_result(1'b0, '0, 1'b0, 1'b1);
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      poly_q      = GEN_BITS_RST;
      poly_len_q  = GEN_LEN_RST;
      wide_data_q = DW_EIGHT_RST;
      clear_frame();
      results_due.delete();
      results_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GEN_BITS: poly_q      = cfg_data_i[GEN_W-1:0];
          CFG_GEN_LEN:  poly_len_q  = cfg_data_i[GEN_LEN_W-1:0];
          CFG_DW_EIGHT: wide_data_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result transaction", $realtime);
            $display("  actual   has=%0d dw=%02h err=%0d cws=%0d errs=%0d fin=%0d",
                     out_data_i.has_codeword, out_data_i.dataword,
                     out_data_i.codeword_error, out_data_i.codewords_seen,
                     out_data_i.errors_seen, out_data_i.final_result);
          end
        end else begin
          want = results_due.pop_front();
          if (out_data_i.has_codeword !== want.has_codeword ||
              out_data_i.dataword !== want.dataword ||
              out_data_i.codeword_error !== want.codeword_error ||
              out_data_i.codewords_seen !== want.codewords_seen ||
              out_data_i.errors_seen !== want.errors_seen ||
              out_data_i.final_result !== want.final_result) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected has=%0d dw=%02h err=%0d cws=%0d errs=%0d fin=%0d",
                       want.has_codeword, want.dataword, want.codeword_error,
                       want.codewords_seen, want.errors_seen, want.final_result);
              $display("  actual   has=%0d dw=%02h err=%0d cws=%0d errs=%0d fin=%0d",
                       out_data_i.has_codeword, out_data_i.dataword,
                       out_data_i.codeword_error, out_data_i.codewords_seen,
                       out_data_i.errors_seen, out_data_i.final_result);
            end
          end
        end
      end
      if (push && !full) frame_byte(in_data_i);
      results_due_o <= results_due.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

// ----- dv/crc_codeword_stream_checker_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the CRC codeword stream checker: clock, reset, stimulus and verdict.
module crc_codeword_stream_checker_test;
  import ccsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 240;
  localparam int MAX_LEN       = 17;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  in_item_t             in_data   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int mismatch_count;
  int results_due;
  int items_sent   = 0;
  int pop_wait     = 0;
  bit pop_steady   = 1'b0;
  bit push_steady  = 1'b0;

  logic [GEN_W-1:0]     cur_poly = GEN_BITS_RST;
  logic [GEN_LEN_W-1:0] cur_len  = GEN_LEN_RST;
  logic                 cur_wide = DW_EIGHT_RST;
  bit                   stream_bits[$];

  always #5 clk_i = ~clk_i;

  crc_codeword_stream_checker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  ccsc_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_data_i       (in_data),
    .empty           (empty),
    .pop             (pop),
    .out_data_i      (out_data),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .results_due_o   (results_due)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int clamp_len(logic [GEN_LEN_W-1:0] len);
    if (len < 2) return 2;
    if (len > MAX_LEN) return MAX_LEN;
    return len;
  endfunction

  always @(posedge clk_i) begin
    if (pop_wait > 0) begin
      pop      <= 1'b0;
      pop_wait <= pop_wait - 1;
    end else begin
      pop <= 1'b1;
      if (!pop_steady && $urandom_range(3) == 0) pop_wait <= pick_gap();
    end
  end

  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    push    <= 1'b1;
    in_data <= '{data_byte: b, last_byte: lst};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    gap = push_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes every register, upper data bits random where the register is narrow.
  task automatic write_cfg(logic [GEN_W-1:0] poly, logic [GEN_LEN_W-1:0] len, logic wide);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GEN_BITS;
    cfg_data  <= poly;
    @(posedge clk_i);
    cfg_index <= CFG_GEN_LEN;
    cfg_data  <= {12'($urandom), len};
    @(posedge clk_i);
    cfg_index <= CFG_DW_EIGHT;
    cfg_data  <= {16'($urandom), wide};
    @(posedge clk_i);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 17'($urandom);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_poly = poly;
    cur_len  = len;
    cur_wide = wide;
  endtask

  // Header, padding, encoded codewords, random tail up to a byte boundary.
  task automatic send_stream(logic [7:0] hdr, int n_cw, int corrupt_pct, bit end_it);
    int          glen, deg, dw, size, nbytes, i, k, x;
    logic [31:0] gen, cw, rem;
    logic [7:0]  b;
    stream_bits.delete();
    glen = clamp_len(cur_len);
    deg  = glen - 1;
    dw   = cur_wide ? 8 : 4;
    size = dw + deg;
    gen  = 32'(cur_poly) & ((32'd1 << glen) - 1);
    repeat (hdr) stream_bits.push_back(1'($urandom_range(1)));
    repeat (n_cw) begin
      cw  = (32'($urandom) & ((32'd1 << dw) - 1)) << deg;
      rem = cw;
      for (x = 0; x < dw; x++) begin
        if (rem[size-1-x]) rem ^= gen << (dw - 1 - x);
      end
      cw |= rem & ((32'd1 << deg) - 1);
      if ($urandom_range(99) < corrupt_pct) cw ^= 32'd1 << $urandom_range(size - 1);
      for (i = size - 1; i >= 0; i--) stream_bits.push_back(cw[i]);
    end
    while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(1)));
    nbytes = stream_bits.size() / 8;
    send_byte(hdr, end_it && nbytes == 0);
    for (k = 0; k < nbytes; k++) begin
      for (i = 0; i < 8; i++) b[7-i] = stream_bits[8*k+i];
      send_byte(b, end_it && k == nbytes - 1);
    end
  endtask

  initial begin
    int               directed_items, glen, n_streams, nb;
    logic [GEN_W-1:0] poly;
    logic [4:0]       len;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration, clean stream, header marked last, all-zero and all-one data
    send_stream(8'd0, 2, 0, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // shortest codeword, three codewords after three padding bits
    settle();
    write_cfg(17'h00003, 5'd2, 1'b0);
    send_stream(8'd3, 3, 0, 1'b1);
    // longest codeword, clean then corrupted
    settle();
    write_cfg(17'h11021, 5'd17, 1'b1);
    send_stream(8'd0, 1, 0, 1'b1);
    send_stream(8'd0, 1, 100, 1'b1);
    // leading coefficient zero
    settle();
    write_cfg(17'h00005, 5'd5, 1'b0);
    send_stream(8'd1, 2, 0, 1'b1);
    // lengths out of range
    settle();
    write_cfg(17'h1FFFF, 5'd0, 1'b0);
    send_stream(8'd0, 2, 0, 1'b1);
    settle();
    write_cfg(17'h1FFFF, 5'd31, 1'b1);
    send_stream(8'd0, 1, 0, 1'b1);
    // configuration changed mid-codeword
    settle();
    write_cfg(17'h00107, 5'd9, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    settle();
    write_cfg(17'h00007, 5'd3, 1'b0);
    send_byte(8'h5A, 1'b1);
    directed_items = items_sent;

    while (items_sent < directed_items + RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(19))
        0:       len = 5'($urandom_range(1));
        1:       len = 5'($urandom_range(18, 31));
        default: len = 5'($urandom_range(2, 17));
      endcase
      glen = clamp_len(len);
      poly = 17'($urandom);
      if ($urandom_range(4) != 0) poly[glen-1] = 1'b1;
      write_cfg(poly, len, 1'($urandom_range(1)));
      pop_steady  = $urandom_range(3) == 0;
      push_steady = $urandom_range(3) == 0;
      n_streams   = $urandom_range(1, 3);
      repeat (n_streams) begin
        if ($urandom_range(3) != 0) begin
          send_stream(($urandom_range(29) == 0) ? 8'($urandom_range(255)) :
                                                  8'($urandom_range(12)),
                      $urandom_range(1, 6), 30, $urandom_range(9) != 0);
        end else begin
          nb = $urandom_range(1, 6);
          repeat (nb - 1) send_byte(8'($urandom), 1'b0);
          send_byte(8'($urandom), $urandom_range(2) != 0);
        end
      end
    end

    settle();
    if (mismatch_count == 0 && empty) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", results_due);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
design/ccsc_pkg.sv
design/ccsc_fifo.sv
design/ccsc_front.sv
design/ccsc_back.sv
design/crc_codeword_stream_checker.sv
design/ccsc_checker.sv
dv/ccsc_result_checker.sv
dv/crc_codeword_stream_checker_test.sv
